// File: design/bounded_ordered_set_defines.svh
// Assertion macros used by the bounded ordered set top level.
// Has no dependencies; include it by its bare file name.
`ifndef BOUNDED_ORDERED_SET_DEFINES_SVH
`define BOUNDED_ORDERED_SET_DEFINES_SVH

// Property must hold at every rising clock edge outside reset.
`define BOS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define BOS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: design/bos_pkg.sv
// Shared types and constants for the bounded ordered set.
// No dependencies; used by bos_cell and bounded_ordered_set.
package bos_pkg;

   localparam int CAPACITY = 8;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LIM_W    = (CNT_W > 4) ? CNT_W : 4;
   localparam int VALUE_W  = 32;

   localparam logic [3:0] CAP_LIMIT_RESET = 4'd8;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]   count_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic live;    // cell index lies below the fill count
      logic remove;  // a remove transaction is accepted this cycle
      logic insert;  // this cell is the append slot of an accepted insert
   } cell_ctl_type;

endpackage

// File: design/bounded_ordered_set.sv
// Top level of the bounded ordered set: a row of storage cells, fill count,
// capacity register and the result register. Depends on bos_pkg, bos_cell
// and bounded_ordered_set_defines.svh.
`include "bounded_ordered_set_defines.svh"

// The block keeps up to CAPACITY signed 32-bit values in insertion order in
// a row of cells. Each request transaction carries an operation in tuser
// (insert, remove or membership query; the unused code acts as a query) and
// the value in tdata. Every request produces exactly one response giving a
// status, a found flag and the entry count after the operation. All cells
// compare the value in parallel and a hit chain running along the row finds
// the first match; on a remove, that cell and every later one take the value
// of their right-hand neighbour, so the set compacts in the same cycle.
// A request is therefore resolved in the cycle it is accepted, and the response appears in the
// result register on the next edge; a new request is taken every cycle as
// long as the result register is empty or being emptied. The capacity limit
// register may be written only while the block is idle; values above
// CAPACITY are treated as CAPACITY, and lowering it below the current count
// keeps the entries but drops inserts until removes make room.
module bounded_ordered_set (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value (signed)
   input  logic [1:0]  req_tuser,  // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [1:0] status, [2] found, [6:3] entry_count, [7] zero
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata   // capacity_limit
);
   import bos_pkg::*;

   logic [3:0]   cap_limit_ff;
   count_type    count_ff;
   count_type    count_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [7:0]   rsp_data_ff;
   logic [7:0]   rsp_data_in;

   logic [LIM_W-1:0] eff_limit;
   logic             room;
   logic             req_fire;
   op_type           op;
   status_type       status;
   logic             hit_any;
   logic             is_insert;
   logic             is_remove;
   logic             do_insert;
   logic             do_remove;

   logic      hit_chain [CAPACITY+1];
   value_type cell_entry [CAPACITY];

   // The response register decouples the two sides: a new request enters
   // whenever the held response is absent or leaves in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);

   assign eff_limit = (LIM_W'(cap_limit_ff) > LIM_W'(CAPACITY)) ?
                      LIM_W'(CAPACITY) : LIM_W'(cap_limit_ff);
   assign room      = LIM_W'(count_ff) < eff_limit;

   assign is_insert = (op == OP_INSERT);
   assign is_remove = (op == OP_REMOVE);
   assign hit_chain[0] = 1'b0;
   assign hit_any      = hit_chain[CAPACITY];
   assign do_insert    = req_fire && is_insert && !hit_any && room;
   assign do_remove    = req_fire && is_remove && hit_any;

   // The row of cells; the last cell shifts in zero, which is never read
   // because the count drops on the same edge.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctl_type ctl;
      value_type    next_entry;

      assign ctl.live   = count_type'(i) < count_ff;
      assign ctl.remove = req_fire && is_remove;
      assign ctl.insert = do_insert && (count_ff == count_type'(i));

      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_body
         assign next_entry = cell_entry[i+1];
      end

      bos_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value      (req_tdata),
         .next_entry (next_entry),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .entry      (cell_entry[i])
      );
   end

   // Status of the current request.
   always_comb begin
      case (op)
         OP_INSERT: begin
            if (hit_any) begin
               status = ST_DUPLICATE;
            end else if (!room) begin
               status = ST_FULL;
            end else begin
               status = ST_DONE;
            end
         end
         default: begin
            // Remove, query and the unused code all report presence.
            status = hit_any ? ST_DONE : ST_NOT_FOUND;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + count_type'(1);
      end else if (do_remove) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, 4'(count_in), hit_any, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_limit_ff <= CAP_LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_limit_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count can never pass the number of cells.
   `BOS_NEVER(a_count_bound, clock, reset, count_ff > count_type'(CAPACITY), "count above capacity")
   // An accepted insert with a done status grows the set by exactly one.
   `BOS_ASSERT(a_insert_grows, clock, reset, (req_fire && is_insert && status == ST_DONE) |=> (count_ff == $past(count_ff) + count_type'(1)), "insert did not grow count")
   // A full drop never coincides with a hit.
   `BOS_NEVER(a_full_no_hit, clock, reset, rsp_valid_ff && rsp_data_ff[1:0] == ST_FULL && rsp_data_ff[2], "full status with found set")
   // A successful remove shrinks the set by one.
   `BOS_ASSERT(a_remove_shrinks, clock, reset, do_remove |=> (count_ff == $past(count_ff) - count_type'(1)), "remove did not shrink count")

endmodule

// File: design/bos_cell.sv
// One storage cell of the ordered set: a stored value, its compare and shift.
// Depends on bos_pkg.
module bos_cell (
   input  logic                 clock,
   input  bos_pkg::cell_ctl_type ctl,
   input  bos_pkg::value_type   value,
   input  bos_pkg::value_type   next_entry,
   input  logic                 hit_in,
   output logic                 hit_out,
   output bos_pkg::value_type   entry
);
   import bos_pkg::*;

   value_type entry_ff;
   value_type entry_in;

   // The hit chain marks this cell and every cell after the first match.
   assign hit_out = hit_in | (ctl.live & (entry_ff == value));
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.remove && hit_out) begin
         entry_in = next_entry;
      end else if (ctl.insert) begin
         entry_in = value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: verif/tb_bounded_ordered_set.sv
// Self-checking testbench for bounded_ordered_set: inserts, removes and queries on the
// bounded set, across several capacity settings and handshake idling patterns.
// Depends on bos_pkg and the bounded_ordered_set design; reads nothing at run time.
module tb_bounded_ordered_set;
   import bos_pkg::*;

   // The fourth operation code is unused by the design and must act as a query.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Idling patterns for the two handshake sides.
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_RECV   = 2;
   localparam int IDLE_BOTH   = 3;

   localparam int CYCLE_LIMIT = 100000;
   localparam int LONG_HOLD   = 120;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] val;
   } set_request_type;

   typedef struct {
      status_type status;
      logic       found;
      logic [3:0] count;
   } set_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   bounded_ordered_set dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Requests waiting to be offered, and the replies the set is still owed.
   set_request_type request_backlog[$];
   set_reply_type   replies_due[$];

   // Our own copy of the set, kept in step with every accepted transaction.
   logic [31:0] set_vals[CAPACITY];
   int          set_fill;
   logic [3:0]  cap_reg;

   set_request_type next_req;
   set_reply_type   got_reply;
   logic         req_taken = 1'b0;
   int           idle_mode = IDLE_NONE;
   bit           hold_arm = 1'b0;
   int           hold_left = 0;
   int           cycle_count = 0;
   int           mismatch_count = 0;
   int           reply_count = 0;
   int           request_count = 0;
   int           status_seen[4];
   int           cap_writes = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Works out the reply to one request and updates our copy of the set.
   // A lookup only ever looks below the fill count, so stale slots are never read.
   function automatic set_reply_type apply_set_op(logic [1:0] op, logic [31:0] val);
      set_reply_type r;
      int limit;
      int pos;
      int i;
      logic hit;
      limit = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
      hit = 1'b0;
      pos = 0;
      for (i = 0; i < set_fill; i++) begin
         if (!hit && set_vals[i] == val) begin
            hit = 1'b1;
            pos = i;
         end
      end
      case (op)
         OP_INSERT: begin
            if (hit) begin
               r.status = ST_DUPLICATE;
            end else if (set_fill >= limit) begin
               r.status = ST_FULL;
            end else begin
               set_vals[set_fill] = val;
               set_fill++;
               r.status = ST_DONE;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               for (i = pos; i + 1 < set_fill; i++) set_vals[i] = set_vals[i + 1];
               set_fill--;
               r.status = ST_DONE;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            // Query, and the spare code which behaves the same way.
            r.status = hit ? ST_DONE : ST_NOT_FOUND;
         end
      endcase
      r.found = hit;
      r.count = 4'(set_fill);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatch_count++;
      // Keep the log readable if the design is badly broken; every mismatch still counts.
      if (mismatch_count <= 40)
         $display("MISMATCH at reply %0d, %s: expected %0h, got %0h",
                  reply_count, what, exp_v, got_v);
   endtask

   // Monitor and checker: everything here samples at the rising edge, while all
   // stimulus changes at the falling edge, so nothing hinges on event ordering.
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (reset) begin
         set_fill = 0;
         cap_reg = CAP_LIMIT_RESET;
      end else begin
         if (csr_we) cap_reg = csr_wdata;
         // A reply leaving now belongs to a request accepted at an earlier edge,
         // so it is checked before this edge's request joins the queue.
         if (rsp_tvalid && rsp_tready) begin
            reply_count++;
            if (replies_due.size() == 0) begin
               report_mismatch("reply with nothing outstanding", '0, 32'(rsp_tdata));
            end else begin
               got_reply = replies_due.pop_front();
               if (rsp_tdata[1:0] !== got_reply.status)
                  report_mismatch("status", 32'(got_reply.status), 32'(rsp_tdata[1:0]));
               if (rsp_tdata[2] !== got_reply.found)
                  report_mismatch("found", 32'(got_reply.found), 32'(rsp_tdata[2]));
               if (rsp_tdata[6:3] !== got_reply.count)
                  report_mismatch("entry_count", 32'(got_reply.count), 32'(rsp_tdata[6:3]));
            end
         end
         if (req_taken) begin
            request_count++;
            replies_due.push_back(apply_set_op(req_tuser, req_tdata));
            status_seen[replies_due[$].status]++;
         end
      end
   end

   // Driver: a request stays on the bus until its transaction completes; a new one
   // (or an idle cycle) is chosen only once the previous one has gone.
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (!reset && request_backlog.size() > 0 &&
             !((idle_mode == IDLE_SENDER && chance(46)) ||
               (idle_mode == IDLE_BOTH && chance(9)))) begin
            next_req = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.op;
            req_tdata  <= next_req.val;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls by phase, plus one long hold-off that it counts itself.
   // During the hold the single result register fills and the input must stall.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_arm) begin
         hold_arm = 1'b0;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !((idle_mode == IDLE_RECV && chance(46)) ||
                         (idle_mode == IDLE_BOTH && chance(9)));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d replies still owed",
                  cycle_count, replies_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic add_request(logic [1:0] op, logic [31:0] val);
      set_request_type r;
      r.op = op;
      r.val = val;
      request_backlog.push_back(r);
   endtask

   // Blocks until every request has gone out and every reply has come back.
   // Each request always yields a reply, so the set is then truly idle.
   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_tvalid || replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(logic [3:0] limit);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= limit;
      @(negedge clock);
      csr_we <= 1'b0;
      cap_writes++;
   endtask

   // Random traffic over a small pool of values, so that inserts meet duplicates,
   // removes find their targets and the set fills up; a share of fully random
   // values keeps every data bit moving.
   task automatic queue_random_requests(int n);
      logic [31:0] pool[12];
      logic [31:0] val;
      logic [1:0]  op;
      int k;
      int pick;
      for (k = 0; k < 12; k++) begin
         case ($urandom_range(5))
            0: pool[k] = 32'h8000_0000;
            1: pool[k] = 32'h7fff_ffff;
            2: pool[k] = 32'h0000_0000;
            3: pool[k] = 32'hffff_ffff;
            default: pool[k] = $urandom;
         endcase
      end
      for (k = 0; k < n; k++) begin
         val = chance(85) ? pool[$urandom_range(11)] : 32'($urandom);
         pick = $urandom_range(99);
         if (pick < 42) op = OP_INSERT;
         else if (pick < 72) op = OP_REMOVE;
         else if (pick < 95) op = OP_QUERY;
         else op = OP_SPARE;
         add_request(op, val);
      end
   endtask

   initial begin
      // Capacity settings run through both extremes, saturation above the
      // parameter, and limits below a count the set already holds.
      int phase_cap[9]   = '{3, 15, 0, 8, 2, 1, 9, 5, 8};
      int phase_idle[9]  = '{IDLE_SENDER, IDLE_NONE, IDLE_RECV, IDLE_BOTH, IDLE_SENDER,
                             IDLE_RECV, IDLE_NONE, IDLE_BOTH, IDLE_RECV};
      int phase_items[9] = '{150, 150, 120, 200, 150, 120, 200, 150, 180};
      int p;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening at the reset capacity: extreme values, each operation,
      // a duplicate insert, a miss on remove and query, the spare code acting as
      // a query, removal from the front with compaction, and filling until full.
      add_request(OP_INSERT, 32'h8000_0000);
      add_request(OP_INSERT, 32'h7fff_ffff);
      add_request(OP_INSERT, 32'h0000_0000);
      add_request(OP_INSERT, 32'hffff_ffff);
      add_request(OP_INSERT, 32'h0000_0000);
      add_request(OP_QUERY,  32'h7fff_ffff);
      add_request(OP_QUERY,  32'h0000_0005);
      add_request(OP_SPARE,  32'hffff_ffff);
      add_request(OP_SPARE,  32'h5555_aaaa);
      add_request(OP_REMOVE, 32'h8000_0000);
      add_request(OP_REMOVE, 32'h0000_3039);
      add_request(OP_QUERY,  32'h0000_0000);
      add_request(OP_INSERT, 32'h0000_0001);
      add_request(OP_INSERT, 32'h0000_0002);
      add_request(OP_INSERT, 32'h0000_0003);
      add_request(OP_INSERT, 32'haaaa_5555);
      add_request(OP_INSERT, 32'h0000_0005);
      add_request(OP_INSERT, 32'h0000_0006);
      add_request(OP_REMOVE, 32'hffff_ffff);
      add_request(OP_QUERY,  32'h0000_0005);
      add_request(OP_INSERT, 32'h8000_0000);
      add_request(OP_INSERT, 32'h0000_0007);
      wait_drained();

      // The set now holds more entries than the first limit allows; later limits
      // are written onto whatever the random traffic left behind.
      for (p = 0; p < 9; p++) begin
         write_capacity(4'(phase_cap[p]));
         idle_mode = phase_idle[p];
         // In the first phase with no idling, the receiver holds off for a long stretch
         // while requests keep coming.
         if (p == 1) hold_arm = 1'b1;
         queue_random_requests(phase_items[p] / 2);
         // The sender pauses here until every owed reply has arrived.
         wait_drained();
         queue_random_requests(phase_items[p] - phase_items[p] / 2);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests and %0d replies over %0d capacity writes",
               request_count, reply_count, cap_writes);
      $display("Replies by status: done %0d, duplicate %0d, full %0d, not found %0d",
               status_seen[ST_DONE], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
               status_seen[ST_NOT_FOUND]);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
